// ----- hdl/tctm_pkg.sv -----
// shared constants, types and arithmetic helpers of the crosstalk trace mixer
package tctm_pkg;

  localparam int CHANNELS  = 4;
  localparam int TIME_BINS = 4096;
  localparam int NUM_IN_CH = 4;

  localparam int CH_W     = 2;
  localparam int BIN_W    = 12;
  localparam int SAMPLE_W = 16;
  localparam int SCALE_W  = 32;
  localparam int TRACE_W  = 40;
  localparam int CFG_W    = 3;

  localparam int PROD_W    = SCALE_W + SAMPLE_W;
  localparam int ACC_W     = PROD_W + $clog2(NUM_IN_CH);
  localparam int FRAC_DROP = 14;
  localparam int RND_W     = ACC_W + 1 - FRAC_DROP;

  localparam int SRC_W     = $clog2(NUM_IN_CH);
  localparam int STEPS     = NUM_IN_CH * NUM_IN_CH;
  localparam int STEP_W    = $clog2(STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);
  localparam logic [SRC_W-1:0]  LAST_SRC  = SRC_W'(NUM_IN_CH - 1);

  localparam int MEM_DEPTH = CHANNELS * CHANNELS * TIME_BINS;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam int PADDR_W  = 3;
  localparam int APB_DW   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_CHANNELS_IN_USE = '0;
  localparam logic [CFG_W-1:0]     CHANNELS_RESET      = CFG_W'(4);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic              capture;
    logic              write;
    logic              issue;
    logic [STEP_W-1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_status_t;

  // number of channels that take part, bounded by the hardware
  function automatic logic [CFG_W-1:0] active_count(input logic [CFG_W-1:0] cfg);
    int n;
    n = int'(cfg);
    if (n > CHANNELS) n = CHANNELS;
    if (n > NUM_IN_CH) n = NUM_IN_CH;
    return CFG_W'(n);
  endfunction

  // q.30 sum to q.16, half rounds up; the rounded value is narrower than
  // the trace, so the saturation bound is never reached
  function automatic logic signed [TRACE_W-1:0] round_sat(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W:0]   biased;
    logic signed [RND_W-1:0] r;
    biased = (ACC_W+1)'(acc) + (ACC_W+1)'(1 << (FRAC_DROP - 1));
    r      = biased[ACC_W:FRAC_DROP];
    return TRACE_W'(r);
  endfunction

endpackage

// ----- hdl/tctm_ctrl.sv -----
// sequencer: accepts commands and steps the datapath through the sixteen template reads
module tctm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 op_i,
  input  tctm_pkg::dp_status_t status_i,
  output tctm_pkg::dp_cmd_t    cmd_o,
  output logic                 busy_o,
  output logic                 result_valid_o
);
  import tctm_pkg::*;

  ctrl_state_e       state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    step_d         = step_q;
    cmd_o          = '0;
    busy_o         = 1'b1;
    result_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.write   = !op_i;
          cmd_o.capture = op_i;
          if (op_i) begin
            state_d = S_READ;
            step_d  = '0;
          end
        end
      end
      S_READ: begin
        cmd_o.issue = 1'b1;
        cmd_o.step  = step_q;
        step_d      = step_q + STEP_W'(1);
        if (step_q == LAST_STEP) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (status_i.done) state_d = S_DONE;
      end
      S_DONE: begin
        result_valid_o = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_done_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.done |-> state_q == S_DRAIN)
    else $error("datapath finished outside drain");

  a_strobe_then_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy_o)
    else $error("still busy after result");

  a_read_to_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && step_q == LAST_STEP) |=> state_q == S_DRAIN)
    else $error("read sweep did not end");

  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && op_i) |=> (busy_o && !result_valid_o))
    else $error("compute not started");

endmodule

// ----- hdl/tctm_datapath.sv -----
// template memory, shared multiply-accumulate and trace result registers
module tctm_datapath (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  tctm_pkg::dp_cmd_t                       cmd_i,
  input  logic [tctm_pkg::CFG_W-1:0]              channels_i,
  input  logic [tctm_pkg::CH_W-1:0]               dest_channel_i,
  input  logic [tctm_pkg::CH_W-1:0]               source_channel_i,
  input  logic [tctm_pkg::BIN_W-1:0]              time_bin_i,
  input  logic signed [tctm_pkg::SAMPLE_W-1:0]    template_sample_i,
  input  logic signed [tctm_pkg::SCALE_W-1:0]     scale_i [tctm_pkg::NUM_IN_CH],
  output tctm_pkg::dp_status_t                    status_o,
  output logic [tctm_pkg::BIN_W-1:0]              out_bin_o,
  output logic signed [tctm_pkg::TRACE_W-1:0]     trace_o [tctm_pkg::NUM_IN_CH]
);
  import tctm_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [MEM_DEPTH];

  logic signed [SCALE_W-1:0]  scale_q [NUM_IN_CH];
  logic [BIN_W-1:0]           bin_q;
  logic [CFG_W-1:0]           n_q;
  logic signed [TRACE_W-1:0]  trace_q [NUM_IN_CH];

  logic                       wr_ok;
  logic [MEM_AW-1:0]          waddr, raddr;
  logic [SRC_W-1:0]           rd_c, rd_s;

  logic                       v1_q, v2_q, v3_q;
  logic [SRC_W-1:0]           c1_q, c2_q, c3_q, s1_q, s2_q, s3_q;
  logic signed [SAMPLE_W-1:0] rdata_q;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic                       last_src;

  assign wr_ok = int'(dest_channel_i) < CHANNELS && int'(source_channel_i) < CHANNELS &&
                 int'(time_bin_i) < TIME_BINS;
  assign waddr = MEM_AW'((int'(dest_channel_i) * CHANNELS + int'(source_channel_i))
                         * TIME_BINS + int'(time_bin_i));

  assign rd_c  = cmd_i.step[STEP_W-1:SRC_W];
  assign rd_s  = cmd_i.step[SRC_W-1:0];
  assign raddr = MEM_AW'((int'(rd_c) * CHANNELS + int'(rd_s)) * TIME_BINS + int'(bin_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && wr_ok) mem[waddr] <= template_sample_i;
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr];
  end

  // transaction operands held for the whole computation
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      scale_q <= scale_i;
      bin_q   <= time_bin_i;
      n_q     <= (int'(time_bin_i) < TIME_BINS) ? active_count(channels_i) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // inactive source channels add nothing
  always_comb begin
    prod_d = '0;
    if (CFG_W'(s1_q) < n_q) prod_d = scale_q[s1_q] * rdata_q;
  end

  assign last_src = v3_q && s3_q == LAST_SRC;

  always_ff @(posedge clk_i) begin
    c1_q   <= rd_c;
    s1_q   <= rd_s;
    c2_q   <= c1_q;
    s2_q   <= s1_q;
    c3_q   <= c2_q;
    s3_q   <= s2_q;
    prod_q <= prod_d;
    if (v2_q) acc_q <= (s2_q == '0) ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    if (last_src) trace_q[c3_q] <= (CFG_W'(c3_q) < n_q) ? round_sat(acc_q) : '0;
  end

  assign status_o.done = last_src && c3_q == LAST_SRC;
  assign out_bin_o     = bin_q;
  assign trace_o       = trace_q;

endmodule

// ----- hdl/template_crosstalk_trace_mix.sv -----
// top level of the crosstalk trace mixer: register port, sequencer and datapath
//
// channel   | handshake                      | payload
// ----------+--------------------------------+---------------------------------------------
// command   | start_i / busy_o               | op_i, dest/source_channel_i, time_bin_i,
//           |                                | template_sample_i, scale_0_i .. scale_3_i
// result    | result_valid_o (one cycle)     | out_bin_o, trace_0_o .. trace_3_o
// config    | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// a load transaction writes the template memory at the accept edge and busy_o stays low
// a compute transaction runs 16 template reads from the single memory port
//   through one shared multiply-accumulate, a drain of the read, product and sum registers, then the strobe
// the strobe follows the drain, start is taken again next cycle
// reset clears the sequencer and sets channels_in_use to 4; the template memory is not cleared
// the receiver cannot stall: the result is shown for exactly one cycle
module template_crosstalk_trace_mix (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 op_i,
  input  logic [tctm_pkg::CH_W-1:0]            dest_channel_i,
  input  logic [tctm_pkg::CH_W-1:0]            source_channel_i,
  input  logic [tctm_pkg::BIN_W-1:0]           time_bin_i,
  input  logic signed [tctm_pkg::SAMPLE_W-1:0] template_sample_i,
  input  logic signed [tctm_pkg::SCALE_W-1:0]  scale_0_i,
  input  logic signed [tctm_pkg::SCALE_W-1:0]  scale_1_i,
  input  logic signed [tctm_pkg::SCALE_W-1:0]  scale_2_i,
  input  logic signed [tctm_pkg::SCALE_W-1:0]  scale_3_i,
  output logic                                 result_valid_o,
  output logic [tctm_pkg::BIN_W-1:0]           out_bin_o,
  output logic signed [tctm_pkg::TRACE_W-1:0]  trace_0_o,
  output logic signed [tctm_pkg::TRACE_W-1:0]  trace_1_o,
  output logic signed [tctm_pkg::TRACE_W-1:0]  trace_2_o,
  output logic signed [tctm_pkg::TRACE_W-1:0]  trace_3_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tctm_pkg::PADDR_W-1:0]         paddr,
  input  logic [tctm_pkg::APB_DW-1:0]          pwdata,
  output logic [tctm_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready
);
  import tctm_pkg::*;

  logic [CFG_W-1:0]          channels_q;
  logic                      cfg_wr;
  logic [REG_IDX_W-1:0]      reg_idx;
  dp_cmd_t                   cmd;
  dp_status_t                status;
  logic signed [SCALE_W-1:0] scale [NUM_IN_CH];
  logic signed [TRACE_W-1:0] trace [NUM_IN_CH];

  // register port: one word per register, low address bits ignored
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channels_q <= CHANNELS_RESET;
    end else if (cfg_wr && reg_idx == REG_CHANNELS_IN_USE) begin
      channels_q <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_CHANNELS_IN_USE) prdata = APB_DW'(channels_q);
  end

  // scale factors by source channel
  assign scale[0] = scale_0_i;
  assign scale[1] = scale_1_i;
  assign scale[2] = scale_2_i;
  assign scale[3] = scale_3_i;

  tctm_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .op_i           (op_i),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o)
  );

  tctm_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .channels_i        (channels_q),
    .dest_channel_i    (dest_channel_i),
    .source_channel_i  (source_channel_i),
    .time_bin_i        (time_bin_i),
    .template_sample_i (template_sample_i),
    .scale_i           (scale),
    .status_o          (status),
    .out_bin_o         (out_bin_o),
    .trace_o           (trace)
  );

  // trace samples by output channel
  assign trace_0_o = trace[0];
  assign trace_1_o = trace[1];
  assign trace_2_o = trace[2];
  assign trace_3_o = trace[3];

endmodule

// ----- tb/template_crosstalk_trace_mix_test.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the crosstalk trace mixer with a built-in prediction of each bin
module template_crosstalk_trace_mix_test;
  import tctm_pkg::*;

  // command codes of the op field
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic [PADDR_W-1:0] CHAN_ADDR = {REG_CHANNELS_IN_USE, 2'b00};
  localparam int SLOTS        = CHANNELS * CHANNELS;
  localparam int DRAIN_CYCLES = 30;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no transaction before giving up
  localparam int PHASE_ITEMS  = 190;
  localparam int REPORT_MAX   = 10;

  localparam logic [SCALE_W-1:0]  SCALE_MIN  = {1'b1, {(SCALE_W-1){1'b0}}};
  localparam logic [SCALE_W-1:0]  SCALE_MAX  = {1'b0, {(SCALE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  typedef struct packed {
    logic                                 op;
    logic [CH_W-1:0]                      dst;
    logic [CH_W-1:0]                      src;
    logic [BIN_W-1:0]                     bin;
    logic [SAMPLE_W-1:0]                  sample;
    logic [NUM_IN_CH-1:0][SCALE_W-1:0]    scale;
  } mix_cmd_t;

  typedef struct packed {
    logic [BIN_W-1:0]                     bin;
    logic [NUM_IN_CH-1:0][TRACE_W-1:0]    trace;
  } trace_set_t;

  // clock, reset and block ports
  logic                       clk_i;
  logic                       rst_ni = 1'b0;
  logic                       start_i = 1'b0;
  logic                       busy_o;
  logic                       op_i = OP_LOAD;
  logic [CH_W-1:0]            dest_channel_i = '0;
  logic [CH_W-1:0]            source_channel_i = '0;
  logic [BIN_W-1:0]           time_bin_i = '0;
  logic signed [SAMPLE_W-1:0] template_sample_i = '0;
  logic signed [SCALE_W-1:0]  scale_0_i = '0;
  logic signed [SCALE_W-1:0]  scale_1_i = '0;
  logic signed [SCALE_W-1:0]  scale_2_i = '0;
  logic signed [SCALE_W-1:0]  scale_3_i = '0;
  logic                       result_valid_o;
  logic [BIN_W-1:0]           out_bin_o;
  logic signed [TRACE_W-1:0]  trace_0_o;
  logic signed [TRACE_W-1:0]  trace_1_o;
  logic signed [TRACE_W-1:0]  trace_2_o;
  logic signed [TRACE_W-1:0]  trace_3_o;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [PADDR_W-1:0]         paddr = '0;
  logic [APB_DW-1:0]          pwdata = '0;
  logic [APB_DW-1:0]          prdata;
  logic                       pready;

  // predictor state: own copy of the template memory and of the channel setting
  logic [SAMPLE_W-1:0]  tmpl_mem [CHANNELS][CHANNELS][TIME_BINS];
  logic [CFG_W-1:0]     chan_setting = CHANNELS_RESET;

  // which template slots of each bin were written, and the bins that are complete
  logic [SLOTS-1:0]     bin_fill [TIME_BINS];
  int                   full_bins [$];

  mix_cmd_t             pending_cmds [$];
  trace_set_t           expected_traces [$];
  int                   send_idle_pct = 0;
  int                   mismatch_count = 0;
  int                   quiet_cycles = 0;

  mix_cmd_t             drv_item;
  logic                 drv_free;
  trace_set_t           mon_want;
  trace_set_t           mon_got;

  template_crosstalk_trace_mix dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .op_i              (op_i),
    .dest_channel_i    (dest_channel_i),
    .source_channel_i  (source_channel_i),
    .time_bin_i        (time_bin_i),
    .template_sample_i (template_sample_i),
    .scale_0_i         (scale_0_i),
    .scale_1_i         (scale_1_i),
    .scale_2_i         (scale_2_i),
    .scale_3_i         (scale_3_i),
    .result_valid_o    (result_valid_o),
    .out_bin_o         (out_bin_o),
    .trace_0_o         (trace_0_o),
    .trace_1_o         (trace_1_o),
    .trace_2_o         (trace_2_o),
    .trace_3_o         (trace_3_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // expected traces of one compute transaction: per active output channel, the sum over
  // active source channels of scale times template, rounded half up to q.16 and clamped
  function automatic trace_set_t mix_bin(input mix_cmd_t c);
    trace_set_t r;
    int         n;
    longint     acc;
    longint     q;
    longint     hi;
    r.bin   = c.bin;
    r.trace = '0;
    hi = (longint'(1) <<< (TRACE_W - 1)) - 1;
    n  = (int'(chan_setting) > CHANNELS) ? CHANNELS : int'(chan_setting);
    if (n > NUM_IN_CH) n = NUM_IN_CH;
    if (int'(c.bin) >= TIME_BINS) n = 0;
    for (int d = 0; d < n; d++) begin
      acc = 0;
      for (int s = 0; s < n; s++)
        acc += longint'($signed(c.scale[s])) * longint'($signed(tmpl_mem[d][s][c.bin]));
      q = (acc + 64'sd8192) >>> 14;
      if (q > hi) q = hi;
      if (q < -hi - 1) q = -hi - 1;
      r.trace[d] = q[TRACE_W-1:0];
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  // scale factors lean on the extremes now and then
  function automatic logic [SCALE_W-1:0] rand_scale();
    case ($urandom_range(0, 19))
      0: return SCALE_MIN;
      1: return SCALE_MAX;
      2: return '0;
      3: return '1;
      4: return SCALE_W'($urandom_range(0, 1) ? 1 << 16 : $urandom_range(0, 255));
      default: return SCALE_W'($urandom);
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 15))
      0: return SAMPLE_MIN;
      1: return SAMPLE_MAX;
      2: return '0;
      3: return SAMPLE_W'(1 << 14);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // fields that the op does not use still carry random content
  function automatic mix_cmd_t noise_cmd();
    mix_cmd_t c;
    c.op     = OP_LOAD;
    c.dst    = CH_W'($urandom);
    c.src    = CH_W'($urandom);
    c.bin    = BIN_W'($urandom);
    c.sample = SAMPLE_W'($urandom);
    for (int s = 0; s < NUM_IN_CH; s++) c.scale[s] = SCALE_W'($urandom);
    return c;
  endfunction

  task automatic push_load(input int dst, input int src, input int bin,
                           input logic [SAMPLE_W-1:0] sample);
    mix_cmd_t c;
    int       slot;
    c        = noise_cmd();
    c.op     = OP_LOAD;
    c.dst    = CH_W'(dst);
    c.src    = CH_W'(src);
    c.bin    = BIN_W'(bin);
    c.sample = sample;
    slot     = dst * CHANNELS + src;
    if (bin_fill[bin] != '1) begin
      bin_fill[bin][slot] = 1'b1;
      if (bin_fill[bin] == '1) full_bins.push_back(bin);
    end
    pending_cmds.push_back(c);
  endtask

  task automatic push_compute(input int bin, input logic [NUM_IN_CH-1:0][SCALE_W-1:0] scales);
    mix_cmd_t c;
    c       = noise_cmd();
    c.op    = OP_COMPUTE;
    c.bin   = BIN_W'(bin);
    c.scale = scales;
    pending_cmds.push_back(c);
  endtask

  task automatic push_random_compute(input int bin);
    logic [NUM_IN_CH-1:0][SCALE_W-1:0] scales;
    for (int s = 0; s < NUM_IN_CH; s++) scales[s] = rand_scale();
    push_compute(bin, scales);
  endtask

  // well-formed sequence: every slot of one bin in shuffled order, then a compute on it
  task automatic fill_bin(input int bin);
    int order [SLOTS];
    int j;
    int t;
    for (int k = 0; k < SLOTS; k++) order[k] = k;
    for (int k = SLOTS - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      t        = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    for (int k = 0; k < SLOTS; k++)
      push_load(order[k] / CHANNELS, order[k] % CHANNELS, bin, rand_sample());
    push_random_compute(bin);
  endtask

  // computes only ever address complete bins, so no unwritten template is read
  task automatic random_run(input int count);
    int made;
    int pick;
    int bin;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (full_bins.size() == 0 || pick < 15) begin
        fill_bin($urandom_range(0, TIME_BINS - 1));
        made += SLOTS + 1;
      end else if (pick < 65) begin
        push_random_compute(full_bins[$urandom_range(0, full_bins.size() - 1)]);
        made++;
      end else if (pick < 85) begin
        // rewrite one slot of a complete bin
        bin = full_bins[$urandom_range(0, full_bins.size() - 1)];
        push_load($urandom_range(0, CHANNELS - 1), $urandom_range(0, CHANNELS - 1), bin,
                  rand_sample());
        made++;
      end else begin
        // stray write, most likely leaves a bin incomplete
        push_load($urandom_range(0, CHANNELS - 1), $urandom_range(0, CHANNELS - 1),
                  $urandom_range(0, TIME_BINS - 1), rand_sample());
        made++;
      end
    end
  endtask

  // hold off until the block has nothing left in flight
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_cmds.size() != 0 || start_i || expected_traces.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // register write: setup cycle, then access cycle until pready
  task automatic reg_write(input logic [CFG_W-1:0] value);
    logic [APB_DW-1:0] word;
    word = $urandom;
    word[CFG_W-1:0] = value;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CHAN_ADDR;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    chan_setting = value;
  endtask

  task automatic reg_check(input logic [CFG_W-1:0] want);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CHAN_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    if (prdata !== APB_DW'(want)) note_mismatch("channels_in_use readback", 64'(want), 64'(prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // driver: a transaction is taken when start is high and busy is low; the prediction is
  // made right at that edge so it sees every earlier template write and no later one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      drv_free = !start_i;
      if (start_i && !busy_o) begin
        drv_free = 1'b1;
        if (drv_item.op == OP_LOAD) begin
          tmpl_mem[drv_item.dst][drv_item.src][drv_item.bin] = drv_item.sample;
        end else begin
          expected_traces.push_back(mix_bin(drv_item));
        end
      end
      if (drv_free) begin
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drv_item = pending_cmds.pop_front();
          start_i           <= 1'b1;
          op_i              <= drv_item.op;
          dest_channel_i    <= drv_item.dst;
          source_channel_i  <= drv_item.src;
          time_bin_i        <= drv_item.bin;
          template_sample_i <= drv_item.sample;
          scale_0_i         <= drv_item.scale[0];
          scale_1_i         <= drv_item.scale[1];
          scale_2_i         <= drv_item.scale[2];
          scale_3_i         <= drv_item.scale[3];
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobe is checked against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      mon_got.bin      = out_bin_o;
      mon_got.trace[0] = trace_0_o;
      mon_got.trace[1] = trace_1_o;
      mon_got.trace[2] = trace_2_o;
      mon_got.trace[3] = trace_3_o;
      if (expected_traces.size() == 0) begin
        note_mismatch("result with nothing expected", '0, 64'(mon_got.bin));
      end else begin
        mon_want = expected_traces.pop_front();
        if (mon_got.bin !== mon_want.bin)
          note_mismatch("out_bin", 64'(mon_want.bin), 64'(mon_got.bin));
        for (int d = 0; d < NUM_IN_CH; d++)
          if (mon_got.trace[d] !== mon_want.trace[d])
            note_mismatch($sformatf("trace_%0d of bin %0d", d, mon_want.bin),
                          64'(mon_want.trace[d]), 64'(mon_got.trace[d]));
      end
    end
  end

  // watchdog: any accepted transaction on any port counts as progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_valid_o || (psel && penable))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("template_crosstalk_trace_mix regression: fail");
        $finish;
      end
    end
  end

  // phases: channel setting and sender idle share; extremes 0 and 7 among them
  logic [CFG_W-1:0] phase_cfg [8]  = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6, 3'd4};
  int               phase_idle [8] = '{0, 75, 22, 0, 75, 22, 0, 75};

  initial begin
    for (int b = 0; b < TIME_BINS; b++) bin_fill[b] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    reg_check(CHANNELS_RESET);

    // directed part at the reset setting: last bin filled with the sample extremes,
    // except one slot at one half so the rounding of exact halves shows
    send_idle_pct = 0;
    for (int d = 0; d < CHANNELS; d++)
      for (int s = 0; s < CHANNELS; s++)
        push_load(d, s, TIME_BINS - 1,
                  (d == 0 && s == 0) ? SAMPLE_W'(1 << 13) :
                  (((d + s) % 2) != 0) ? SAMPLE_MAX : SAMPLE_MIN);
    push_compute(TIME_BINS - 1, {NUM_IN_CH{SCALE_MIN}});
    push_compute(TIME_BINS - 1, {NUM_IN_CH{SCALE_MAX}});
    push_compute(TIME_BINS - 1, {SCALE_MAX, SCALE_MIN, SCALE_MAX, SCALE_MIN});
    // plus half rounds up to one, minus half rounds up to zero
    push_compute(TIME_BINS - 1, (NUM_IN_CH*SCALE_W)'(1));
    push_compute(TIME_BINS - 1, {{(NUM_IN_CH-1)*SCALE_W{1'b0}}, {SCALE_W{1'b1}}});
    push_compute(TIME_BINS - 1, '0);
    fill_bin(0);
    wait_drained();

    // random phases, each entered with the block idle; the drain at every phase end
    // makes the sender pause until every expected result has come
    for (int p = 0; p < 8; p++) begin
      reg_write(phase_cfg[p]);
      reg_check(phase_cfg[p]);
      send_idle_pct = phase_idle[p];
      random_run(PHASE_ITEMS);
      wait_drained();
    end

    if (expected_traces.size() != 0)
      note_mismatch("results still outstanding", '0, 64'(expected_traces.size()));
    if (mismatch_count == 0) begin
      $display("template_crosstalk_trace_mix regression: pass");
    end else begin
      $display("template_crosstalk_trace_mix regression: fail");
    end
    $finish;
  end

endmodule
